// ===== design/top_flow_counter_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the top-flow counter table
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TOP_FLOW_COUNTER_TABLE_TOP_MACROS_SVH
`define TOP_FLOW_COUNTER_TABLE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TFCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tfct_pkg.sv =====
// ----------------------------------------------------------------------------
// tfct_pkg
// Types and constants shared by the top-flow counter table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfct_pkg;

	// Protocol and register constants.
	localparam logic [7:0]  PROTO_TCP   = 8'd6;
	localparam logic [15:0] LIMIT_RESET = 16'd1000;
	localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
	localparam logic        KIND_READ   = 1'b1;

	// Slot index width wide enough for the largest supported table.
	localparam int SLOT_IDX_W = 8;

	typedef enum logic [2:0] {
		ACT_IGNORED  = 3'd0,
		ACT_HIT      = 3'd1,
		ACT_INSERTED = 3'd2,
		ACT_REPLACED = 3'd3,
		ACT_READ     = 3'd4
	} action_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [3:0]  read_slot;
	} in_item_t;

	typedef struct packed {
		action_t     action;
		logic [3:0]  slot;
		logic [31:0] entry_count;
		logic [31:0] entry_source;
		logic [31:0] entry_dest;
		logic [15:0] entry_port;
	} result_t;

	// Flow key and one table entry as stored in memory.
	typedef struct packed {
		logic [31:0] source;
		logic [31:0] dest;
		logic [15:0] port;
	} key_t;

	typedef struct packed {
		logic [31:0] count;
		key_t        key;
	} entry_t;

	// Outcome of one pass over the table.
	typedef struct packed {
		logic                  hit;
		logic [SLOT_IDX_W-1:0] hit_idx;
		logic [31:0]           hit_count;
		logic                  empty;
		logic [SLOT_IDX_W-1:0] empty_idx;
		logic [SLOT_IDX_W-1:0] min_idx;
	} scan_result_t;

endpackage

`default_nettype wire

// ===== design/top_flow_counter_table_top.sv =====
// ----------------------------------------------------------------------------
// top_flow_counter_table_top
// Counts TCP flows in a small table, evicting the lowest-count flow.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   cfg       in         cfg_wr_en             cfg_wr_data (source port limit)
//   in        in         in_valid / in_stall   in_data  (tfct_pkg::in_item_t)
//   out       out        out_valid / out_stall out_data (tfct_pkg::result_t)
//
// For a counted packet, the single read port of the table memory is stepped
// over every slot, then the ST_LAST state finishes the pass and ST_WRITE
// writes back. A read passes through ST_READ; an ignored packet goes to ST_DONE.
// Reset clears the slot valid flags at once; there is no clearing pass.
// The output register holds a finished beat while the next item is accepted;
// a stall on the output delays only the hand-off of the following result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "top_flow_counter_table_top_macros.svh"

module top_flow_counter_table_top #(
	parameter int SLOTS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [15:0]       cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire tfct_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output tfct_pkg::result_t      out_data
);

	import tfct_pkg::*;

	localparam int IW  = $clog2(SLOTS);
	localparam int RSW = (IW > 4) ? IW : 4;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_LAST  = 6'b000100,
		ST_WRITE = 6'b001000,
		ST_READ  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t         state_q;
	logic [15:0]    limit_q;
	logic [SLOTS-1:0] valid_q;
	logic [IW-1:0]  addr_q;
	key_t           key_q;
	logic [3:0]     rslot_q;
	logic           in_range_q;
	result_t        res_q;
	logic           out_valid_q;
	result_t        out_data_q;

	logic           beat_valid_s1;
	logic [IW-1:0]  beat_idx_s1;
	logic           used_s1;

	logic           in_acc;
	logic           counted;
	logic           rd_en;
	logic [IW-1:0]  rd_addr;
	logic [RSW-1:0] rs_ext;
	logic           rs_in_range;
	entry_t         rd_data;
	logic           wr_en;
	logic [IW-1:0]  wr_idx;
	entry_t         wr_data;
	logic [IW+3:0]  wr_idx_wide;
	logic [31:0]    new_count;
	action_t        wr_action;
	scan_result_t   scan;
	key_t           in_key;
	logic           out_free;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign in_key.source = in_data.source_address;
	assign in_key.dest   = in_data.dest_address;
	assign in_key.port   = in_data.dest_port;

	assign counted = (in_data.ip_protocol == PROTO_TCP) && (in_data.source_port < limit_q);

	// Read slot index and its range check against the table depth.
	assign rs_ext      = RSW'(in_data.read_slot);
	assign rs_in_range = (9'(in_data.read_slot) < 9'(SLOTS));

	// Memory read port: the scan counter, or the requested slot of a read.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q;
		if (state_q == ST_SCAN) begin
			rd_en = 1'b1;
		end else if (in_acc && in_data.kind == KIND_READ && rs_in_range) begin
			rd_en   = 1'b1;
			rd_addr = rs_ext[IW-1:0];
		end
	end

	// Write-back decision after the pass: hit, then first empty, then minimum.
	always_comb begin
		if (scan.hit) begin
			wr_idx    = scan.hit_idx[IW-1:0];
			new_count = (scan.hit_count == COUNT_MAX) ? COUNT_MAX : scan.hit_count + 32'd1;
			wr_action = ACT_HIT;
		end else if (scan.empty) begin
			wr_idx    = scan.empty_idx[IW-1:0];
			new_count = 32'd1;
			wr_action = ACT_INSERTED;
		end else begin
			wr_idx    = scan.min_idx[IW-1:0];
			new_count = 32'd1;
			wr_action = ACT_REPLACED;
		end
		wr_en         = (state_q == ST_WRITE);
		wr_data.count = new_count;
		wr_data.key   = key_q;
		wr_idx_wide   = {4'b0000, wr_idx};
	end

	tfct_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tfct_scan #(
		.SLOTS(SLOTS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_acc),
		.beat_valid (beat_valid_s1),
		.beat_idx   (beat_idx_s1),
		.beat_used  (used_s1),
		.beat_entry (rd_data),
		.key        (key_q),
		.result     (scan)
	);

	// Read pipeline stage alongside the memory output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_s1 <= 1'b0;
		end else begin
			beat_valid_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			beat_idx_s1 <= rd_addr;
			used_s1     <= valid_q[rd_addr];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Slot valid flags: a slot becomes used on its first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (in_acc) begin
						if (in_data.kind == KIND_READ) begin
							state_q <= ST_READ;
						end else if (counted) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + IW'(1);
					if (addr_q == IW'(SLOTS - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item fields and the pending result.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q      <= in_key;
			rslot_q    <= in_data.read_slot;
			in_range_q <= rs_in_range;
			if (in_data.kind != KIND_READ && !counted) begin
				res_q <= '{action: ACT_IGNORED, default: '0};
			end
		end
		if (state_q == ST_WRITE) begin
			res_q.action       <= wr_action;
			res_q.slot         <= wr_idx_wide[3:0];
			res_q.entry_count  <= new_count;
			res_q.entry_source <= key_q.source;
			res_q.entry_dest   <= key_q.dest;
			res_q.entry_port   <= key_q.port;
		end
		if (state_q == ST_READ) begin
			res_q.action <= ACT_READ;
			res_q.slot   <= rslot_q;
			if (in_range_q && used_s1) begin
				res_q.entry_count  <= rd_data.count;
				res_q.entry_source <= rd_data.key.source;
				res_q.entry_dest   <= rd_data.key.dest;
				res_q.entry_port   <= rd_data.key.port;
			end else begin
				res_q.entry_count  <= '0;
				res_q.entry_source <= '0;
				res_q.entry_dest   <= '0;
				res_q.entry_port   <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks.
	`TFCT_ASSERT_NEXT(a_count_starts_scan, clk, arst_n, in_acc && in_data.kind != KIND_READ && counted, state_q == ST_SCAN, "counted packet did not start a table pass")
	`TFCT_ASSERT_SAME(a_write_in_range, clk, arst_n, wr_en, (IW + 1)'(wr_idx) < (IW + 1)'(SLOTS), "write-back slot beyond table depth")
	`TFCT_ASSERT_NEXT(a_done_loads_out, clk, arst_n, state_q == ST_DONE && out_free, out_valid && state_q == ST_IDLE, "finished result not moved to output")
	`TFCT_ASSERT_SAME(a_touched_nonzero, clk, arst_n, out_valid && (out_data.action == ACT_HIT || out_data.action == ACT_INSERTED || out_data.action == ACT_REPLACED), out_data.entry_count != 32'd0, "touched slot left with zero count")

endmodule

`default_nettype wire

// ===== design/tfct_ram.sv =====
// ----------------------------------------------------------------------------
// tfct_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/tfct_scan.sv =====
// ----------------------------------------------------------------------------
// tfct_scan
// Tracks key match, first empty slot and lowest count over a table pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfct_scan #(
	parameter int SLOTS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        beat_valid,
	input  wire logic [$clog2(SLOTS)-1:0]    beat_idx,
	input  wire logic                        beat_used,
	input  wire tfct_pkg::entry_t            beat_entry,
	input  wire tfct_pkg::key_t              key,
	output tfct_pkg::scan_result_t           result
);

	import tfct_pkg::*;

	localparam int IW = $clog2(SLOTS);

	logic          hit_q;
	logic          empty_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] empty_idx_q;
	logic [IW-1:0] min_idx_q;
	logic [31:0]   hit_count_q;
	logic [31:0]   min_count_q;
	logic [31:0]   count_eff;
	logic          match;
	logic          take_min;

	// An unused slot reads as empty, whatever the memory holds.
	assign count_eff = beat_used ? beat_entry.count : 32'd0;
	assign match     = beat_used && (beat_entry.key == key);
	assign take_min  = (beat_idx == '0) || (count_eff < min_count_q);

	// Found flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (start) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (beat_valid) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (!beat_used) begin
				empty_q <= 1'b1;
			end
		end
	end

	// Captured indices and counts; the first match and first empty win.
	always_ff @(posedge clk) begin
		if (beat_valid) begin
			if (match && !hit_q) begin
				hit_idx_q   <= beat_idx;
				hit_count_q <= count_eff;
			end
			if (!beat_used && !empty_q) begin
				empty_idx_q <= beat_idx;
			end
			if (take_min) begin
				min_idx_q   <= beat_idx;
				min_count_q <= count_eff;
			end
		end
	end

	always_comb begin
		result.hit       = hit_q;
		result.hit_idx   = SLOT_IDX_W'(hit_idx_q);
		result.hit_count = hit_count_q;
		result.empty     = empty_q;
		result.empty_idx = SLOT_IDX_W'(empty_idx_q);
		result.min_idx   = SLOT_IDX_W'(min_idx_q);
	end

endmodule

`default_nettype wire

// ===== sim/top_flow_counter_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_flow_counter_table_top_tb
// Self-checking bench for the top-flow counter table. A behavioral copy of the
// flow table predicts every result beat. Directed tests cover the filter,
// reads, insertion, hits and eviction order. Random traffic then runs over
// several source port limits, with idle cycles and stalls on both sides.
// ----------------------------------------------------------------------------

module top_flow_counter_table_top_tb;

	import tfct_pkg::*;

	localparam int SLOTS       = 16;
	localparam int POOL_SIZE   = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = SLOTS + 8;
	localparam int WATCHDOG    = 4000;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	in_item_t   in_data     = '0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	result_t    out_data;

	// Behavioral copy of the flow table and the port limit register.
	logic [31:0] flow_src   [SLOTS] = '{default: '0};
	logic [31:0] flow_dst   [SLOTS] = '{default: '0};
	logic [15:0] flow_port  [SLOTS] = '{default: '0};
	logic [31:0] flow_count [SLOTS] = '{default: '0};
	logic [15:0] port_limit = LIMIT_RESET;

	result_t flow_results_due[$];
	key_t    flow_pool[POOL_SIZE];

	bit calm          = 1'b0;
	bit hold_request  = 1'b0;
	int mismatches    = 0;
	int beats_in      = 0;
	int beats_out     = 0;
	int quiet_cycles  = 0;
	int action_seen[5] = '{default: 0};

	top_flow_counter_table_top #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Update the table copy for one accepted beat and return the result it causes.
	function automatic result_t count_flow(input in_item_t it);
		result_t r;
		int      idx;
		bit      found;
		r = '0;
		idx = 0;
		found = 1'b0;
		if (it.kind == KIND_READ) begin
			r.action = ACT_READ;
			r.slot = it.read_slot;
			if (it.read_slot < SLOTS) begin
				r.entry_count  = flow_count[it.read_slot];
				r.entry_source = flow_src[it.read_slot];
				r.entry_dest   = flow_dst[it.read_slot];
				r.entry_port   = flow_port[it.read_slot];
			end
			return r;
		end
		if (it.ip_protocol != PROTO_TCP || it.source_port >= port_limit) begin
			r.action = ACT_IGNORED;
			return r;
		end
		// An empty slot never matches, even on an all-zero key.
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && flow_count[i] != 0 && flow_src[i] == it.source_address &&
					flow_dst[i] == it.dest_address && flow_port[i] == it.dest_port) begin
				found = 1'b1;
				idx = i;
			end
		end
		if (found) begin
			if (flow_count[idx] != COUNT_MAX)
				flow_count[idx]++;
			r.action = ACT_HIT;
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && flow_count[i] == 0) begin
					found = 1'b1;
					idx = i;
				end
			end
			if (found) begin
				r.action = ACT_INSERTED;
			end else begin
				// Lowest count wins, lowest index on ties.
				idx = 0;
				for (int i = 1; i < SLOTS; i++) begin
					if (flow_count[i] < flow_count[idx])
						idx = i;
				end
				r.action = ACT_REPLACED;
			end
			flow_src[idx]   = it.source_address;
			flow_dst[idx]   = it.dest_address;
			flow_port[idx]  = it.dest_port;
			flow_count[idx] = 32'd1;
		end
		r.slot         = idx[3:0];
		r.entry_count  = flow_count[idx];
		r.entry_source = flow_src[idx];
		r.entry_dest   = flow_dst[idx];
		r.entry_port   = flow_port[idx];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Check result beats, predict input beats and watch for a hang.
	always @(posedge clk) begin
		result_t want;
		bit      moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				beats_out++;
				if (out_data.action <= ACT_READ)
					action_seen[out_data.action]++;
				if (flow_results_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, actual %h", $time, out_data);
				end else begin
					want = flow_results_due.pop_front();
					check_field("action", 32'(want.action), 32'(out_data.action));
					check_field("slot", 32'(want.slot), 32'(out_data.slot));
					check_field("entry_count", want.entry_count, out_data.entry_count);
					check_field("entry_source", want.entry_source, out_data.entry_source);
					check_field("entry_dest", want.entry_dest, out_data.entry_dest);
					check_field("entry_port", 32'(want.entry_port),
						32'(out_data.entry_port));
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				beats_in++;
				flow_results_due.push_back(count_flow(in_data));
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Result side: random stalls, none while calm, and a long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
				hold_request = 1'b0;
			end
			out_stall <= !calm && ($urandom_range(99) < 35);
		end
	end

	// Offer one beat after a random idle gap and hold it until accepted.
	task automatic send_item(input in_item_t it);
		while (!calm && $urandom_range(99) < 35) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering and let every result come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (flow_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write the port limit once the block is idle.
	task automatic set_port_limit(input logic [15:0] value);
		drain_results();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		port_limit = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic in_item_t packet(input logic [7:0] proto, input logic [31:0] src,
			input logic [31:0] dst, input logic [15:0] sport, input logic [15:0] dport);
		in_item_t it;
		it = '0;
		it.ip_protocol    = proto;
		it.source_address = src;
		it.dest_address   = dst;
		it.source_port    = sport;
		it.dest_port      = dport;
		it.read_slot      = 4'hF;
		return it;
	endfunction

	function automatic in_item_t read_req(input logic [3:0] slot);
		in_item_t it;
		it = packet(PROTO_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
		it.kind      = KIND_READ;
		it.read_slot = slot;
		return it;
	endfunction

	// Mostly well-formed TCP beats on a pool of flows, plus reads and noise.
	function automatic in_item_t random_item();
		in_item_t it;
		int       pick;
		int       k;
		it.kind           = ~KIND_READ;
		it.ip_protocol    = 8'($urandom);
		it.source_address = $urandom;
		it.dest_address   = $urandom;
		it.source_port    = 16'($urandom);
		it.dest_port      = 16'($urandom);
		it.read_slot      = 4'($urandom);
		pick = $urandom_range(99);
		if (pick < 15) begin
			it.kind = KIND_READ;
		end else if (pick < 20) begin
			it.ip_protocol = PROTO_TCP;
		end else if (pick >= 25) begin
			it.ip_protocol = PROTO_TCP;
			if (port_limit != 0)
				it.source_port = 16'($urandom_range(port_limit - 1));
			if (pick >= 35) begin
				k = $urandom_range(POOL_SIZE - 1);
				it.source_address = flow_pool[k].source;
				it.dest_address   = flow_pool[k].dest;
				it.dest_port      = flow_pool[k].port;
			end
		end
		return it;
	endfunction

	task automatic refill_flow_pool();
		for (int k = 0; k < POOL_SIZE; k++) begin
			flow_pool[k].source = $urandom;
			flow_pool[k].dest   = $urandom;
			flow_pool[k].port   = 16'($urandom);
		end
		flow_pool[0] = '0;
		flow_pool[1] = '1;
	endtask

	// Filter and read behavior under the reset limit.
	task automatic test_filter_and_reads();
		send_item(read_req(4'd0));
		send_item(read_req(4'd15));
		send_item(packet(8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443));
		send_item(packet(8'd0, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443));
		send_item(packet(8'hFF, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443));
		send_item(packet(PROTO_TCP, 32'h0A00_0001, 32'h0A00_0002, LIMIT_RESET, 16'd443));
		send_item(packet(PROTO_TCP, 32'h0A00_0001, 32'h0A00_0002, 16'hFFFF, 16'd443));
		// An all-zero key goes into an empty slot rather than matching it.
		send_item(packet(PROTO_TCP, '0, '0, LIMIT_RESET - 16'd1, '0));
		send_item(packet(PROTO_TCP, '0, '0, 16'd0, '0));
		send_item(packet(PROTO_TCP, '1, '1, 16'd0, '1));
		send_item(read_req(4'd1));
		send_item(read_req(4'd0));
	endtask

	// Fill the table, then check that eviction takes the lowest index among the
	// lowest counts. Saturation at the count maximum is out of reach in a run.
	task automatic test_eviction_order();
		for (int i = 2; i < SLOTS; i++)
			send_item(packet(PROTO_TCP, 32'hC0A8_0000 + i, 32'h0A0A_0000 - i, 16'd1, 16'(i)));
		send_item(packet(PROTO_TCP, '1, '1, 16'd5, '1));
		send_item(packet(PROTO_TCP, 32'h1234_5678, 32'h9ABC_DEF0, 16'd7, 16'd22));
		send_item(packet(PROTO_TCP, 32'h8765_4321, 32'h0FED_CBA9, 16'd7, 16'd25));
		send_item(read_req(4'd2));
	endtask

	// The limit at its extremes and just above zero.
	task automatic test_limit_extremes();
		set_port_limit(16'd0);
		send_item(packet(PROTO_TCP, '1, '1, 16'd0, '1));
		set_port_limit(16'hFFFF);
		send_item(packet(PROTO_TCP, '1, '1, 16'hFFFE, '1));
		send_item(packet(PROTO_TCP, '1, '1, 16'hFFFF, '1));
		set_port_limit(16'd1);
		send_item(packet(PROTO_TCP, '0, '0, 16'd0, '0));
		send_item(packet(PROTO_TCP, '0, '0, 16'd1, '0));
	endtask

	// The result side holds off while beats keep coming, so the block backs up.
	task automatic test_output_holdoff();
		drain_results();
		hold_request = 1'b1;
		for (int n = 0; n < 40; n++)
			send_item(random_item());
		drain_results();
	endtask

	// Random traffic in phases, each with its own limit and flow pool.
	task automatic test_random_traffic();
		logic [15:0] limits [5];
		int          counts [5];
		limits = '{LIMIT_RESET, 16'hFFFF, 16'd0, 16'd1, 16'($urandom)};
		counts = '{150, 150, 40, 150, 186};
		for (int p = 0; p < 5; p++) begin
			set_port_limit(limits[p]);
			refill_flow_pool();
			calm = (p == 1);
			for (int n = 0; n < counts[p]; n++)
				send_item(random_item());
			if (p == 3)
				test_output_holdoff();
		end
		calm = 1'b0;
		drain_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_filter_and_reads();
		test_eviction_order();
		test_limit_extremes();
		test_random_traffic();
		drain_results();

		if (flow_results_due.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time,
				flow_results_due.size());
		end
		$display("Moved %0d input beats and %0d result beats over five port limits.",
			beats_in, beats_out);
		$display("Results: %0d ignored, %0d hits, %0d inserts, %0d evictions, %0d reads.",
			action_seen[ACT_IGNORED], action_seen[ACT_HIT], action_seen[ACT_INSERTED],
			action_seen[ACT_REPLACED], action_seen[ACT_READ]);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
